@@ sv/arp_address_cache_top_assert.svh @@
// Assertion macros for the ARP address cache.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef ARP_ADDRESS_CACHE_TOP_ASSERT_SVH
`define ARP_ADDRESS_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ARPC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ARPC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/arpc_pkg.sv @@
// Shared types and constants for the ARP address cache.
// No dependencies.
package arpc_pkg;

  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;

  localparam logic [MacW-1:0] MacBcast = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

endpackage

@@ sv/arp_address_cache_top.sv @@
// ARP address cache top level: IPv4 to MAC table with a sequential scan.
// Depends on arpc_pkg, arpc_ram and arp_address_cache_top_assert.svh.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | input     | in_valid_i / in_ready_o   | op_i, ip_addr_i, mac_in_i
//   out     | output    | out_valid_o / out_ready_i | mac_out_o, hit_o, dropped_o
//
// Add, clear, reserved op and lookup on an empty table: result registered at the accept edge.
// Lookup: one entry compared per cycle through the table RAM read port, from entry 0
// upward; the first match ends the scan with a hit, else a miss after the last entry.
// Items are taken only in idle and while the result slot is free or draining.
// Reset empties the table (fill count only); RAM contents are not cleared.
`include "arp_address_cache_top_assert.svh"

module arp_address_cache_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [arpc_pkg::IpW-1:0]   ip_addr_i,
  input  logic [arpc_pkg::MacW-1:0]  mac_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [arpc_pkg::MacW-1:0]  mac_out_o,
  output logic                       hit_o,
  output logic                       dropped_o
);

  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned WordW = arpc_pkg::IpW + arpc_pkg::MacW;

  arpc_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [arpc_pkg::IpW-1:0] key_q, key_d;

  logic                      out_valid_q, out_valid_d;
  logic [arpc_pkg::MacW-1:0] mac_out_q, mac_out_d;
  logic                      hit_q, hit_d;
  logic                      dropped_q, dropped_d;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;

  logic in_acc;
  logic slot_free;
  logic full;
  logic last;
  logic match;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == arpc_pkg::ST_IDLE) && slot_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = (fill_q == CntW'(ENTRIES));
  assign last       = (CntW'(idx_q) == (fill_q - CntW'(1)));
  assign match      = (ram_rdata[WordW-1 -: arpc_pkg::IpW] == key_q);

  arpc_ram #(
    .Width (WordW),
    .Depth (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_waddr = fill_q[IdxW-1:0];
  assign ram_wdata = {ip_addr_i, mac_in_i};

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mac_out_d   = mac_out_q;
    hit_d       = hit_q;
    dropped_d   = dropped_q;
    ram_we      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      arpc_pkg::ST_IDLE: begin
        // read address 0 every idle cycle so entry 0 is ready on scan entry
        ram_raddr = '0;
        if (in_acc) begin
          key_d     = ip_addr_i;
          idx_d     = '0;
          mac_out_d = '0;
          hit_d     = 1'b0;
          dropped_d = 1'b0;
          if (op_i == arpc_pkg::OP_LOOKUP) begin
            if (fill_q == '0) begin
              out_valid_d = 1'b1;
              mac_out_d   = arpc_pkg::MacBcast;
            end else begin
              state_d = arpc_pkg::ST_SCAN;
            end
          end else if (op_i == arpc_pkg::OP_ADD) begin
            out_valid_d = 1'b1;
            if (full) begin
              dropped_d = 1'b1;
            end else begin
              ram_we = 1'b1;
              fill_d = fill_q + CntW'(1);
            end
          end else if (op_i == arpc_pkg::OP_CLEAR) begin
            out_valid_d = 1'b1;
            fill_d      = '0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      arpc_pkg::ST_SCAN: begin
        ram_raddr = IdxW'(idx_q + 1'b1);
        if (match) begin
          out_valid_d = 1'b1;
          mac_out_d   = ram_rdata[arpc_pkg::MacW-1:0];
          hit_d       = 1'b1;
          state_d     = arpc_pkg::ST_IDLE;
        end else if (last) begin
          out_valid_d = 1'b1;
          mac_out_d   = arpc_pkg::MacBcast;
          state_d     = arpc_pkg::ST_IDLE;
        end else begin
          idx_d = IdxW'(idx_q + 1'b1);
        end
      end
      default: begin
        state_d = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpc_pkg::ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    mac_out_q <= mac_out_d;
    hit_q     <= hit_d;
    dropped_q <= dropped_d;
  end

  assign out_valid_o = out_valid_q;
  assign mac_out_o   = mac_out_q;
  assign hit_o       = hit_q;
  assign dropped_o   = dropped_q;

  `ARPC_ASSERT_IMP(a_acc_slot_free, in_acc, slot_free, "item accepted with result slot busy")
  `ARPC_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CntW'(ENTRIES), "fill count above table size")
  `ARPC_ASSERT_IMP(a_scan_idx, state_q == arpc_pkg::ST_SCAN, CntW'(idx_q) < fill_q, "scan past fill")
  `ARPC_ASSERT_IMP(a_scan_no_out, state_q == arpc_pkg::ST_SCAN, !out_valid_q, "result during scan")
  `ARPC_ASSERT_NXT(a_drop_full, in_acc && op_i == arpc_pkg::OP_ADD && full, dropped_q && out_valid_q, "full add not flagged")

endmodule

@@ sv/arpc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module arpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/arp_address_cache_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the ARP address cache: watches both channels, keeps its own
// copy of the table and checks every result in order. Depends on arpc_pkg.
module arp_address_cache_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   op_i,
  input  logic [arpc_pkg::IpW-1:0]     ip_addr_i,
  input  logic [arpc_pkg::MacW-1:0]    mac_in_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [arpc_pkg::MacW-1:0]    mac_out_i,
  input  logic                         hit_i,
  input  logic                         dropped_i,
  output int unsigned                  pending_o,
  output int unsigned                  err_count_o,
  output int unsigned                  results_o,
  output int unsigned                  hits_o,
  output int unsigned                  drops_o
);

  typedef struct packed {
    logic [arpc_pkg::MacW-1:0] mac;
    logic                      hit;
    logic                      dropped;
  } arp_reply_t;

  logic [arpc_pkg::IpW-1:0]  ip_tbl  [ENTRIES];
  logic [arpc_pkg::MacW-1:0] mac_tbl [ENTRIES];
  int unsigned     fill = 0;
  arp_reply_t      replies_due[$];
  int unsigned     err_cnt = 0;
  int unsigned     result_cnt = 0;
  int unsigned     hit_cnt = 0;
  int unsigned     drop_cnt = 0;

  // Applies one request to the shadow table and returns the reply it must give.
  function automatic arp_reply_t resolve_request(input logic [1:0] op,
                                                 input logic [arpc_pkg::IpW-1:0] ip,
                                                 input logic [arpc_pkg::MacW-1:0] mac);
    arp_reply_t r;
    r = '0;
    if (op == arpc_pkg::OP_LOOKUP) begin
      r.mac = arpc_pkg::MacBcast;
      // walk downward so the oldest match is the one left standing
      for (int k = int'(fill) - 1; k >= 0; k--) begin
        if (ip_tbl[k] == ip) begin
          r.mac = mac_tbl[k];
          r.hit = 1'b1;
        end
      end
    end else if (op == arpc_pkg::OP_ADD) begin
      if (fill >= ENTRIES) begin
        r.dropped = 1'b1;
      end else begin
        ip_tbl[fill]  = ip;
        mac_tbl[fill] = mac;
        fill++;
      end
    end else if (op == arpc_pkg::OP_CLEAR) begin
      fill = 0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    arp_reply_t due;
    if (!rst_ni) begin
      fill = 0;
      replies_due.delete();
    end else begin
      // results leave before the new item enters; they never belong to it
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing expected: mac_out=%h hit=%0b dropped=%0b",
                   $time, mac_out_i, hit_i, dropped_i);
          err_cnt++;
        end else begin
          due = replies_due.pop_front();
          result_cnt++;
          if (due.hit) hit_cnt++;
          if (due.dropped) drop_cnt++;
          if (mac_out_i !== due.mac) begin
            $display("%0t: mac_out mismatch: expected %h, actual %h",
                     $time, due.mac, mac_out_i);
            err_cnt++;
          end
          if (hit_i !== due.hit) begin
            $display("%0t: hit mismatch: expected %0b, actual %0b", $time, due.hit, hit_i);
            err_cnt++;
          end
          if (dropped_i !== due.dropped) begin
            $display("%0t: dropped mismatch: expected %0b, actual %0b",
                     $time, due.dropped, dropped_i);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due = resolve_request(op_i, ip_addr_i, mac_in_i);
        replies_due.insert(replies_due.size(), due);
      end
    end
    pending_o   <= replies_due.size();
    err_count_o <= err_cnt;
    results_o   <= result_cnt;
    hits_o      <= hit_cnt;
    drops_o     <= drop_cnt;
  end

endmodule

@@ tb/arp_address_cache_top_test.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the ARP address cache: directed corner cases, then
// random add/lookup sessions. Depends on arpc_pkg and arp_address_cache_checker.
module arp_address_cache_top_test;

  localparam int unsigned Entries     = 16;
  localparam logic [1:0]  OpReserved  = 2'd3;
  localparam int unsigned RandomItems = 1950;
  localparam int unsigned PoolSize    = 20;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 2 * Entries + 8;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                op_i = arpc_pkg::OP_LOOKUP;
  logic [arpc_pkg::IpW-1:0]  ip_addr_i = '0;
  logic [arpc_pkg::MacW-1:0] mac_in_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [arpc_pkg::MacW-1:0] mac_out_o;
  logic                      hit_o;
  logic                      dropped_o;

  int unsigned pending, err_count, results, hits, drops;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;

  always #5 clk_i = ~clk_i;

  arp_address_cache_top #(
    .ENTRIES(Entries)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .ip_addr_i  (ip_addr_i),
    .mac_in_i   (mac_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .mac_out_o  (mac_out_o),
    .hit_o      (hit_o),
    .dropped_o  (dropped_o)
  );

  arp_address_cache_checker #(
    .ENTRIES(Entries)
  ) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .op_i       (op_i),
    .ip_addr_i  (ip_addr_i),
    .mac_in_i   (mac_in_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .mac_out_i  (mac_out_o),
    .hit_i      (hit_o),
    .dropped_i  (dropped_o),
    .pending_o  (pending),
    .err_count_o(err_count),
    .results_o  (results),
    .hits_o     (hits),
    .drops_o    (drops)
  );

  // Receiver backpressure: switches between always ready, coin flip, mostly
  // stalled and toggling.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) == 1);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ~out_ready_i;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("arp_address_cache_top_test: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [arpc_pkg::MacW-1:0] random_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[arpc_pkg::MacW-1:0];
  endfunction

  // Holds valid until the item is taken; returns at the accepting edge.
  task automatic send_item(input logic [1:0] op, input logic [arpc_pkg::IpW-1:0] ip,
                           input logic [arpc_pkg::MacW-1:0] mac);
    op_i       <= op;
    ip_addr_i  <= ip;
    mac_in_i   <= mac;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Sender pacing: bursts of random length, mostly with a gap in between.
  task automatic push_item(input logic [1:0] op, input logic [arpc_pkg::IpW-1:0] ip,
                           input logic [arpc_pkg::MacW-1:0] mac);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_item(op, ip, mac);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned              counted;
    int unsigned              session_len;
    int unsigned              pick;
    logic [arpc_pkg::IpW-1:0] ip;
    logic [arpc_pkg::IpW-1:0] ip_pool [PoolSize];

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, reserved op, extreme fields, duplicates, full table
    push_item(arpc_pkg::OP_LOOKUP, 32'h0000_0000, random_mac());
    push_item(OpReserved, 32'hffff_ffff, 48'hffff_ffff_ffff);
    push_item(arpc_pkg::OP_ADD, 32'h0000_0000, 48'h0000_0000_0000);
    push_item(arpc_pkg::OP_ADD, 32'hffff_ffff, 48'hffff_ffff_ffff);
    push_item(arpc_pkg::OP_ADD, 32'h0000_0000, 48'h0123_4567_89ab);
    push_item(arpc_pkg::OP_LOOKUP, 32'h0000_0000, random_mac());
    push_item(arpc_pkg::OP_LOOKUP, 32'hffff_ffff, random_mac());
    push_item(arpc_pkg::OP_LOOKUP, 32'h0a00_0001, random_mac());
    for (int k = 0; k < 13; k++) push_item(arpc_pkg::OP_ADD, 32'h0a00_0000 + k, random_mac());
    push_item(arpc_pkg::OP_ADD, 32'hc0a8_0001, random_mac());
    push_item(arpc_pkg::OP_LOOKUP, 32'h0a00_000c, random_mac());
    push_item(arpc_pkg::OP_CLEAR, 32'hffff_ffff, 48'hffff_ffff_ffff);
    push_item(arpc_pkg::OP_LOOKUP, 32'h0000_0000, random_mac());
    wait_drained();

    // random sessions: each starts with a clear and draws IPs from a small pool
    // so that lookups hit and duplicates and full tables come up
    counted = 0;
    while (counted < RandomItems) begin
      push_item(arpc_pkg::OP_CLEAR, $urandom, random_mac());
      counted++;
      for (int i = 0; i < PoolSize; i++) ip_pool[i] = $urandom;
      session_len = $urandom_range(8, 80);
      for (int n = 0; n < session_len && counted < RandomItems; n++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) != 0) ip = ip_pool[$urandom_range(0, PoolSize - 1)];
        else ip = $urandom;
        if (pick < 3) begin
          push_item(OpReserved, ip, random_mac());
        end else if (pick < 45) begin
          push_item(arpc_pkg::OP_ADD, ip, random_mac());
          counted++;
        end else begin
          push_item(arpc_pkg::OP_LOOKUP, ip, random_mac());
          counted++;
        end
        if ($urandom_range(0, 299) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d items incl. reserved ops and %0d random; %0d results checked,",
             items_sent, counted, results);
    $display("with %0d lookup hits and %0d adds refused on a full table.", hits, drops);
    if (err_count == 0) begin
      $display("arp_address_cache_top_test: PASS");
    end else begin
      $display("arp_address_cache_top_test: FAIL");
    end
    $finish;
  end

endmodule

@@ arp_address_cache_top.f @@
+incdir+sv
sv/arpc_pkg.sv
sv/arpc_ram.sv
sv/arp_address_cache_top.sv
tb/arp_address_cache_checker.sv
tb/arp_address_cache_top_test.sv
